// ===== design/nearest_point_search_macros.svh =====
// Assertion macros used by the nearest point search RTL.
`ifndef NEAREST_POINT_SEARCH_MACROS_SVH
`define NEAREST_POINT_SEARCH_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define NPS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define NPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/nps_pkg.sv =====
// Types and constants of the nearest point search block.
`default_nettype none

package nps_pkg;

  localparam int CoordBits     = 16;
  localparam int DiffBits      = CoordBits + 1;
  localparam int SqBits        = 2 * CoordBits;
  localparam int DistBits      = 2 * CoordBits + 1;
  localparam int IdxBits       = 6;
  localparam int RangeBits     = 16;
  localparam int TableDepthDef = 64;

  typedef enum logic [1:0] {
    ModeWrEntry   = 2'd0,
    ModeWrSpecial = 2'd1,
    ModeQuery     = 2'd2
  } mode_e;

  typedef struct packed {
    mode_e                        mode;
    logic [IdxBits-1:0]           entry_index;
    logic signed [CoordBits-1:0]  pos_x;
    logic signed [CoordBits-1:0]  pos_y;
    logic                         is_active;
    logic                         is_phased;
    logic [RangeBits-1:0]         radius;
    logic                         include_special;
  } in_t;

  typedef struct packed {
    logic                         found;
    logic [IdxBits-1:0]           winner_index;
    logic                         winner_is_special;
    logic signed [CoordBits-1:0]  target_x;
    logic signed [CoordBits-1:0]  target_y;
    logic [DistBits-1:0]          distance_squared;
  } out_t;

  typedef struct packed {
    logic signed [CoordBits-1:0]  x;
    logic signed [CoordBits-1:0]  y;
    logic                         active;
    logic                         phased;
  } point_t;

  // Control tag that travels with a point through the distance pipe.
  typedef struct packed {
    logic vld;
    logic special;
    logic elig;
  } tag_t;

endpackage

`default_nettype wire

// ===== design/nps_cell.sv =====
// One table cell: holds a point entry and rotates it to its neighbor while scanning.
`default_nettype none

module nps_cell (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            shift_i,
  input  wire logic            wr_i,
  input  wire nps_pkg::point_t wr_pt_i,
  input  wire nps_pkg::point_t nb_pt_i,
  output nps_pkg::point_t      pt_o
);

  logic                                 active_q, active_d;
  logic                                 phased_q, phased_d;
  logic signed [nps_pkg::CoordBits-1:0] x_q, x_d;
  logic signed [nps_pkg::CoordBits-1:0] y_q, y_d;

  always_comb begin
    active_d = active_q;
    phased_d = phased_q;
    x_d      = x_q;
    y_d      = y_q;
    if (wr_i) begin
      active_d = wr_pt_i.active;
      phased_d = wr_pt_i.phased;
      x_d      = wr_pt_i.x;
      y_d      = wr_pt_i.y;
    end else if (shift_i) begin
      active_d = nb_pt_i.active;
      phased_d = nb_pt_i.phased;
      x_d      = nb_pt_i.x;
      y_d      = nb_pt_i.y;
    end
  end

  // Flags reset to inactive; coordinates only matter once written.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      phased_q <= 1'b0;
    end else begin
      active_q <= active_d;
      phased_q <= phased_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
  end

  assign pt_o.x      = x_q;
  assign pt_o.y      = y_q;
  assign pt_o.active = active_q;
  assign pt_o.phased = phased_q;

endmodule

`default_nettype wire

// ===== design/nps_dist.sv =====
// Two-stage squared distance pipe: coordinate differences, then squares.
`default_nettype none

module nps_dist #(
  parameter int IDX_W = 6
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire nps_pkg::tag_t                        tag_i,
  input  wire logic [IDX_W-1:0]                     idx_i,
  input  wire logic signed [nps_pkg::CoordBits-1:0] pt_x_i,
  input  wire logic signed [nps_pkg::CoordBits-1:0] pt_y_i,
  input  wire logic signed [nps_pkg::CoordBits-1:0] org_x_i,
  input  wire logic signed [nps_pkg::CoordBits-1:0] org_y_i,
  output nps_pkg::tag_t                             tag_o,
  output logic [IDX_W-1:0]                          idx_o,
  output logic signed [nps_pkg::CoordBits-1:0]      x_o,
  output logic signed [nps_pkg::CoordBits-1:0]      y_o,
  output logic [nps_pkg::SqBits-1:0]                sq_x_o,
  output logic [nps_pkg::SqBits-1:0]                sq_y_o
);

  // stage A: differences
  nps_pkg::tag_t                        tag_a_q;
  logic [IDX_W-1:0]                     idx_a_q;
  logic signed [nps_pkg::CoordBits-1:0] x_a_q, y_a_q;
  logic signed [nps_pkg::DiffBits-1:0]  dx_a_q, dx_a_d;
  logic signed [nps_pkg::DiffBits-1:0]  dy_a_q, dy_a_d;

  // stage B: squares
  nps_pkg::tag_t                        tag_b_q;
  logic [IDX_W-1:0]                     idx_b_q;
  logic signed [nps_pkg::CoordBits-1:0] x_b_q, y_b_q;
  logic [nps_pkg::SqBits-1:0]           sqx_b_q, sqx_b_d;
  logic [nps_pkg::SqBits-1:0]           sqy_b_q, sqy_b_d;
  logic signed [2*nps_pkg::DiffBits-1:0] prod_x, prod_y;

  assign dx_a_d = $signed({pt_x_i[nps_pkg::CoordBits-1], pt_x_i})
                - $signed({org_x_i[nps_pkg::CoordBits-1], org_x_i});
  assign dy_a_d = $signed({pt_y_i[nps_pkg::CoordBits-1], pt_y_i})
                - $signed({org_y_i[nps_pkg::CoordBits-1], org_y_i});

  // squares are below 2^32, so the low bits hold them exactly
  assign prod_x  = dx_a_q * dx_a_q;
  assign prod_y  = dy_a_q * dy_a_q;
  assign sqx_b_d = prod_x[nps_pkg::SqBits-1:0];
  assign sqy_b_d = prod_y[nps_pkg::SqBits-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_a_q <= '0;
      tag_b_q <= '0;
    end else begin
      tag_a_q <= tag_i;
      tag_b_q <= tag_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_a_q <= idx_i;
    x_a_q   <= pt_x_i;
    y_a_q   <= pt_y_i;
    dx_a_q  <= dx_a_d;
    dy_a_q  <= dy_a_d;
    idx_b_q <= idx_a_q;
    x_b_q   <= x_a_q;
    y_b_q   <= y_a_q;
    sqx_b_q <= sqx_b_d;
    sqy_b_q <= sqy_b_d;
  end

  assign tag_o  = tag_b_q;
  assign idx_o  = idx_b_q;
  assign x_o    = x_b_q;
  assign y_o    = y_b_q;
  assign sq_x_o = sqx_b_q;
  assign sq_y_o = sqy_b_q;

endmodule

`default_nettype wire

// ===== design/nearest_point_search.sv =====
// A table write, special write or unused-mode item yields an all-zero result.
// A query rotates the cell chain once past a single distance unit: its result is formed in
// the scan, special and drain states and output from finish; the next item is taken only in idle.
// Rate is one table entry per cycle, set by the rotation and the shared distance pipe.
// A finished result waits in the output register while the next item is processed.
// Reset (rst_ni low, asynchronous) clears all entries and the special point to inactive.
`default_nettype none

`include "nearest_point_search_macros.svh"

module nearest_point_search #(
  parameter int TABLE_DEPTH = nps_pkg::TableDepthDef
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire nps_pkg::in_t in_i,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output nps_pkg::out_t     out_o
);

  localparam int CntW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StSpec,
    StDrain,
    StFinish
  } state_e;

  state_e                               state_q;
  logic [CntW-1:0]                      cnt_q;
  logic signed [nps_pkg::CoordBits-1:0] org_x_q, org_y_q;
  logic [nps_pkg::SqBits-1:0]           limit_q;
  logic                                 limited_q;
  logic                                 inc_sp_q;
  nps_pkg::point_t                      sp_q;
  logic                                 have_q;
  logic [nps_pkg::DistBits-1:0]         best_q;
  logic [CntW-1:0]                      best_idx_q;
  logic                                 best_sp_q;
  logic signed [nps_pkg::CoordBits-1:0] best_x_q, best_y_q;
  nps_pkg::out_t                        res_q, res_d;
  nps_pkg::out_t                        out_q;
  logic                                 out_vld_q;

  logic                                 accept;
  logic                                 wr_entry;
  logic                                 shift;
  nps_pkg::point_t                      wr_pt;
  nps_pkg::point_t                      cell_pt [TABLE_DEPTH];
  nps_pkg::point_t                      head;
  nps_pkg::tag_t                        feed_tag;
  logic signed [nps_pkg::CoordBits-1:0] feed_x, feed_y;

  nps_pkg::tag_t                        tag_b;
  logic [CntW-1:0]                      idx_b;
  logic signed [nps_pkg::CoordBits-1:0] x_b, y_b;
  logic [nps_pkg::SqBits-1:0]           sq_x_b, sq_y_b;
  logic [nps_pkg::DistBits-1:0]         cand_dist;
  logic                                 take_tab, take_sp, upd;
  logic                                 have_n, best_sp_n;
  logic [nps_pkg::DistBits-1:0]         best_n;
  logic [CntW-1:0]                      best_idx_n;
  logic signed [nps_pkg::CoordBits-1:0] best_x_n, best_y_n;
  logic [CntW+nps_pkg::IdxBits-1:0]     idx_wide;
  logic                                 finalize;

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;
  assign wr_entry   = accept && (in_i.mode == nps_pkg::ModeWrEntry);
  assign shift      = (state_q == StScan);

  assign wr_pt.x      = in_i.pos_x;
  assign wr_pt.y      = in_i.pos_y;
  assign wr_pt.active = in_i.is_active;
  assign wr_pt.phased = in_i.is_phased;

  // Cell i takes cell i+1 while scanning, so entry k sits in cell 0 at scan step k.
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    localparam int Nxt = (i + 1) % TABLE_DEPTH;
    logic we;
    assign we = wr_entry && (int'(in_i.entry_index) == i);
    nps_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .wr_i    (we),
      .wr_pt_i (wr_pt),
      .nb_pt_i (cell_pt[Nxt]),
      .pt_o    (cell_pt[i])
    );
  end

  assign head = cell_pt[0];

  always_comb begin
    feed_tag = '0;
    feed_x   = head.x;
    feed_y   = head.y;
    if (state_q == StScan) begin
      feed_tag.vld  = 1'b1;
      feed_tag.elig = head.active && !head.phased;
    end else if (state_q == StSpec) begin
      feed_tag.vld     = 1'b1;
      feed_tag.special = 1'b1;
      feed_tag.elig    = inc_sp_q && sp_q.active;
      feed_x           = sp_q.x;
      feed_y           = sp_q.y;
    end
  end

  nps_dist #(
    .IDX_W (CntW)
  ) u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tag_i   (feed_tag),
    .idx_i   (cnt_q),
    .pt_x_i  (feed_x),
    .pt_y_i  (feed_y),
    .org_x_i (org_x_q),
    .org_y_i (org_y_q),
    .tag_o   (tag_b),
    .idx_o   (idx_b),
    .x_o     (x_b),
    .y_o     (y_b),
    .sq_x_o  (sq_x_b),
    .sq_y_o  (sq_y_b)
  );

  // Compare stage: strict less-than keeps the lower index on ties.
  assign cand_dist = {1'b0, sq_x_b} + {1'b0, sq_y_b};
  assign take_tab = tag_b.vld && !tag_b.special && tag_b.elig &&
                    (have_q ? (cand_dist < best_q)
                            : (!limited_q || (cand_dist < {1'b0, limit_q})));
  assign take_sp  = tag_b.vld && tag_b.special && tag_b.elig &&
                    (!have_q || (cand_dist < best_q));
  assign upd      = take_tab || take_sp;

  assign have_n     = upd ? 1'b1      : have_q;
  assign best_n     = upd ? cand_dist : best_q;
  assign best_sp_n  = upd ? take_sp   : best_sp_q;
  assign best_idx_n = take_sp ? '0 : (upd ? idx_b : best_idx_q);
  assign best_x_n   = upd ? x_b       : best_x_q;
  assign best_y_n   = upd ? y_b       : best_y_q;
  assign idx_wide   = {{nps_pkg::IdxBits{1'b0}}, best_idx_n};

  assign finalize = (state_q == StDrain) && tag_b.vld && tag_b.special;

  always_comb begin
    res_d = '0;
    if (have_n) begin
      res_d.found             = 1'b1;
      res_d.winner_index      = idx_wide[nps_pkg::IdxBits-1:0];
      res_d.winner_is_special = best_sp_n;
      res_d.target_x          = best_x_n;
      res_d.target_y          = best_y_n;
      res_d.distance_squared  = best_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      cnt_q      <= '0;
      org_x_q    <= '0;
      org_y_q    <= '0;
      limit_q    <= '0;
      limited_q  <= 1'b0;
      inc_sp_q   <= 1'b0;
      sp_q       <= '0;
      have_q     <= 1'b0;
      best_q     <= '0;
      best_idx_q <= '0;
      best_sp_q  <= 1'b0;
      best_x_q   <= '0;
      best_y_q   <= '0;
      res_q      <= '0;
      out_q      <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      if (out_vld_q && out_ready_i && (state_q != StFinish)) begin
        out_vld_q <= 1'b0;
      end
      if (upd) begin
        have_q     <= have_n;
        best_q     <= best_n;
        best_idx_q <= best_idx_n;
        best_sp_q  <= best_sp_n;
        best_x_q   <= best_x_n;
        best_y_q   <= best_y_n;
      end
      unique case (state_q)
        StIdle: begin
          if (accept) begin
            res_q <= '0;
            case (in_i.mode)
              nps_pkg::ModeWrSpecial: begin
                sp_q.x      <= in_i.pos_x;
                sp_q.y      <= in_i.pos_y;
                sp_q.active <= in_i.is_active;
                sp_q.phased <= 1'b0;
                state_q     <= StFinish;
              end
              nps_pkg::ModeQuery: begin
                org_x_q   <= in_i.pos_x;
                org_y_q   <= in_i.pos_y;
                limit_q   <= nps_pkg::SqBits'(in_i.radius) * nps_pkg::SqBits'(in_i.radius);
                limited_q <= (in_i.radius != '0);
                inc_sp_q  <= in_i.include_special;
                have_q    <= 1'b0;
                best_sp_q <= 1'b0;
                cnt_q     <= '0;
                state_q   <= StScan;
              end
              default: begin
                state_q <= StFinish;
              end
            endcase
          end
        end
        StScan: begin
          if (cnt_q == CntW'(TABLE_DEPTH - 1)) begin
            cnt_q   <= '0;
            state_q <= StSpec;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        StSpec: begin
          state_q <= StDrain;
        end
        StDrain: begin
          if (finalize) begin
            res_q   <= res_d;
            state_q <= StFinish;
          end
        end
        StFinish: begin
          if (!out_vld_q || out_ready_i) begin
            out_q     <= res_q;
            out_vld_q <= 1'b1;
            state_q   <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_o       = out_q;

  `NPS_ASSERT_NEXT(a_scan_wrap, (state_q == StScan) && (cnt_q == CntW'(TABLE_DEPTH - 1)), state_q == StSpec, "scan did not end after one full rotation")
  `NPS_ASSERT_NOW(a_special_reaches_cmp, state_q == StSpec, ##2 (tag_b.vld && tag_b.special && finalize), "special point did not reach the compare stage on time")
  `NPS_ASSERT_NOW(a_special_index_zero, out_vld_q && out_q.winner_is_special, out_q.found && (out_q.winner_index == '0), "special winner carries a table index")
  `NPS_ASSERT_NOW(a_have_clear_on_query, $fell(have_q), $past(accept) && ($past(in_i.mode) == nps_pkg::ModeQuery), "best candidate dropped outside a query start")

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench of nearest_point_search: stalls on both channels, own scan model.
`default_nettype none

module tb;

  localparam int Depth = nps_pkg::TableDepthDef;
  localparam int CoordBits = nps_pkg::CoordBits;
  localparam int IdxBits = nps_pkg::IdxBits;
  localparam int DistBits = nps_pkg::DistBits;
  localparam int RangeBits = nps_pkg::RangeBits;
  localparam int CycleLimit = 500000;
  localparam int TailCycles = Depth + 40;
  localparam int ItemsPerPhase = 200;
  localparam logic [1:0] ModeUnused = 2'd3;
  localparam int CoordMin = -32768;
  localparam int CoordMax = 32767;

  typedef struct {
    nps_pkg::in_t item;
    int  phase;
    bit  drain_first;
  } queued_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  nps_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  nps_pkg::out_t out_data;

  queued_item_t items_to_send[$];
  nps_pkg::out_t wanted_results[$];
  int errors = 0;
  int cycle_count = 0;
  int run_phase = 0;
  bit took_item = 1'b0;

  // shadow copy of the point table and the special point
  logic signed [CoordBits-1:0] tbl_x[Depth];
  logic signed [CoordBits-1:0] tbl_y[Depth];
  bit tbl_act[Depth];
  bit tbl_ph[Depth];
  logic signed [CoordBits-1:0] sp_x = '0;
  logic signed [CoordBits-1:0] sp_y = '0;
  bit sp_act = 1'b0;

  logic signed [CoordBits-1:0] cluster_x, cluster_y;

  nearest_point_search dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_i        (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_o       (out_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Applies one transaction to the shadow state and returns the result it should give.
  function automatic nps_pkg::out_t nearest_after_item(input nps_pkg::in_t it);
    nps_pkg::out_t res;
    longint dx, dy, d, best, limit;
    bit have;
    int i;
    res = '0;
    have = 1'b0;
    best = 0;
    case (it.mode)
      nps_pkg::ModeWrEntry: begin
        tbl_x[it.entry_index] = it.pos_x;
        tbl_y[it.entry_index] = it.pos_y;
        tbl_act[it.entry_index] = it.is_active;
        tbl_ph[it.entry_index] = it.is_phased;
      end
      nps_pkg::ModeWrSpecial: begin
        sp_x = it.pos_x;
        sp_y = it.pos_y;
        sp_act = it.is_active;
      end
      nps_pkg::ModeQuery: begin
        limit = longint'(it.radius) * longint'(it.radius);
        for (i = 0; i < Depth; i++) begin
          if (tbl_act[i] && !tbl_ph[i]) begin
            dx = longint'(tbl_x[i]) - longint'($signed(it.pos_x));
            dy = longint'(tbl_y[i]) - longint'($signed(it.pos_y));
            d = dx * dx + dy * dy;
            // range only gates the first hit; later hits are nearer still
            if (have ? (d < best) : (it.radius == 0 || d < limit)) begin
              have = 1'b1;
              best = d;
              res.winner_index = i[IdxBits-1:0];
              res.target_x = tbl_x[i];
              res.target_y = tbl_y[i];
            end
          end
        end
        // special point ignores the range and must be strictly nearer
        if (it.include_special && sp_act) begin
          dx = longint'(sp_x) - longint'($signed(it.pos_x));
          dy = longint'(sp_y) - longint'($signed(it.pos_y));
          d = dx * dx + dy * dy;
          if (!have || d < best) begin
            have = 1'b1;
            best = d;
            res.winner_index = '0;
            res.winner_is_special = 1'b1;
            res.target_x = sp_x;
            res.target_y = sp_y;
          end
        end
        if (have) begin
          res.found = 1'b1;
          res.distance_squared = best[DistBits-1:0];
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic nps_pkg::in_t make_item(input nps_pkg::mode_e mode, input int idx,
                                             input int x, y, input int act, ph,
                                             input int rng, input int inc);
    nps_pkg::in_t it;
    it.mode = mode;
    it.entry_index = idx[IdxBits-1:0];
    it.pos_x = x[CoordBits-1:0];
    it.pos_y = y[CoordBits-1:0];
    it.is_active = act[0];
    it.is_phased = ph[0];
    it.radius = rng[RangeBits-1:0];
    it.include_special = inc[0];
    return it;
  endfunction

  function automatic logic signed [CoordBits-1:0] random_coord(
      input logic signed [CoordBits-1:0] center);
    logic [CoordBits-1:0] off;
    logic signed [CoordBits-1:0] r;
    off = CoordBits'($urandom_range(48));
    case ($urandom_range(9))
      0, 1: r = CoordBits'($urandom());
      2: r = ($urandom_range(1) != 0) ? CoordMax[CoordBits-1:0] : CoordMin[CoordBits-1:0];
      default: r = center + off - 16'd24;
    endcase
    return r;
  endfunction

  function automatic nps_pkg::in_t random_item();
    nps_pkg::in_t it;
    int pick;
    pick = $urandom_range(99);
    it.mode = (pick < 44) ? nps_pkg::ModeWrEntry : (pick < 52) ? nps_pkg::ModeWrSpecial :
              (pick < 95) ? nps_pkg::ModeQuery : nps_pkg::mode_e'(ModeUnused);
    it.entry_index = IdxBits'($urandom_range(Depth - 1));
    it.pos_x = random_coord(cluster_x);
    it.pos_y = random_coord(cluster_y);
    it.is_active = ($urandom_range(4) != 0);
    it.is_phased = ($urandom_range(4) == 0);
    case ($urandom_range(9))
      0, 1, 2: it.radius = '0;
      3, 4, 5, 6: it.radius = RangeBits'($urandom_range(48, 1));
      7: it.radius = RangeBits'($urandom_range(65535));
      8: it.radius = '1;
      default: it.radius = RangeBits'($urandom_range(4096, 256));
    endcase
    it.include_special = ($urandom_range(1) != 0);
    return it;
  endfunction

  task automatic check_field(input string name, input logic [DistBits-1:0] want, got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  // Driver: new transactions and ready change on the falling edge.
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && !took_item) begin
        // hold until accepted
      end else if (items_to_send.size() != 0 &&
                   !(items_to_send[0].drain_first && wanted_results.size() != 0) &&
                   $urandom_range(99) >= ((items_to_send[0].phase == 0) ? 13 :
                                          (items_to_send[0].phase == 1) ? 70 : 0)) begin
        in_data <= items_to_send[0].item;
        run_phase = items_to_send[0].phase;
        items_to_send.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
      out_ready <= ($urandom_range(99) >= ((run_phase == 0) ? 70 : (run_phase == 1) ? 13 : 0));
    end
  end

  // Monitor: check results first, then record new transactions.
  always @(posedge clk) begin
    nps_pkg::out_t want;
    cycle_count++;
    took_item = 1'b0;
    if (cycle_count > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (wanted_results.size() == 0) begin
          $error("result with no transaction outstanding");
          errors++;
        end else begin
          want = wanted_results.pop_front();
          check_field("found", DistBits'(want.found), DistBits'(out_data.found));
          check_field("winner_index", DistBits'(want.winner_index),
                      DistBits'(out_data.winner_index));
          check_field("winner_is_special", DistBits'(want.winner_is_special),
                      DistBits'(out_data.winner_is_special));
          check_field("target_x", DistBits'(want.target_x), DistBits'(out_data.target_x));
          check_field("target_y", DistBits'(want.target_y), DistBits'(out_data.target_y));
          check_field("distance_squared", want.distance_squared,
                      out_data.distance_squared);
        end
      end
      if (in_valid && in_ready) begin
        wanted_results.push_back(nearest_after_item(in_data));
        took_item = 1'b1;
      end
    end
  end

  initial begin
    queued_item_t q;
    int i;
    for (i = 0; i < Depth; i++) begin
      tbl_x[i] = '0;
      tbl_y[i] = '0;
      tbl_act[i] = 1'b0;
      tbl_ph[i] = 1'b0;
    end
    cluster_x = CoordBits'($urandom());
    cluster_y = CoordBits'($urandom());
    q.phase = 0;
    q.drain_first = 1'b0;

    // empty table, special inactive: nothing found
    q.item = make_item(nps_pkg::ModeQuery, 0, 0, 0, 0, 0, 0, 1); items_to_send.push_back(q);
    // phased flag on a special write has no effect
    q.item = make_item(nps_pkg::ModeWrSpecial, 63, CoordMin, CoordMin, 1, 1, 65535, 1);
    items_to_send.push_back(q);
    q.item = make_item(nps_pkg::ModeWrEntry, 0, CoordMax, CoordMax, 1, 0, 0, 0);
    items_to_send.push_back(q);
    q.item = make_item(nps_pkg::ModeWrEntry, 63, CoordMin, CoordMin, 1, 1, 0, 0);
    items_to_send.push_back(q);
    // special at the same distance as the table winner does not replace it
    q.item = make_item(nps_pkg::ModeQuery, 0, CoordMax, CoordMin, 0, 0, 0, 1);
    items_to_send.push_back(q);
    // largest possible distance
    q.item = make_item(nps_pkg::ModeQuery, 0, CoordMin, CoordMin, 0, 0, 0, 0);
    items_to_send.push_back(q);
    q.item = make_item(nps_pkg::ModeQuery, 0, CoordMin, CoordMin, 0, 0, 0, 1);
    items_to_send.push_back(q);
    q.item = make_item(nps_pkg::ModeQuery, 0, CoordMax, CoordMax, 0, 0, 1, 0);
    items_to_send.push_back(q);
    // equal-distance entries: lower index wins
    q.item = make_item(nps_pkg::ModeWrEntry, 5, 10, 0, 1, 0, 0, 0); items_to_send.push_back(q);
    q.item = make_item(nps_pkg::ModeWrEntry, 6, 10, 0, 1, 0, 0, 0); items_to_send.push_back(q);
    q.item = make_item(nps_pkg::ModeWrEntry, 7, 0, -10, 1, 0, 0, 0);
    items_to_send.push_back(q);
    // distance equal to range squared is out of range
    q.item = make_item(nps_pkg::ModeQuery, 0, 0, 0, 0, 0, 10, 0); items_to_send.push_back(q);
    // special point is not limited by range
    q.item = make_item(nps_pkg::ModeQuery, 0, 0, 0, 0, 0, 10, 1); items_to_send.push_back(q);
    q.item = make_item(nps_pkg::ModeQuery, 0, 0, 0, 0, 0, 11, 0); items_to_send.push_back(q);
    q.item = make_item(nps_pkg::ModeQuery, 0, 0, 0, 0, 0, 65535, 1);
    items_to_send.push_back(q);
    // unused mode leaves state alone
    q.item = make_item(nps_pkg::mode_e'(ModeUnused), 5, CoordMax, CoordMin, 0, 1, 65535, 1);
    items_to_send.push_back(q);
    q.item = make_item(nps_pkg::ModeWrEntry, 5, 10, 0, 0, 0, 0, 0); items_to_send.push_back(q);
    q.item = make_item(nps_pkg::ModeQuery, 0, 0, 0, 0, 0, 0, 0); items_to_send.push_back(q);
    q.item = make_item(nps_pkg::ModeWrEntry, 63, CoordMin, CoordMin, 1, 0, 0, 0);
    items_to_send.push_back(q);
    q.item = make_item(nps_pkg::ModeQuery, 0, CoordMin, CoordMin, 0, 0, 0, 1);
    items_to_send.push_back(q);
    q.item = make_item(nps_pkg::ModeWrSpecial, 0, 0, 0, 0, 0, 0, 0); items_to_send.push_back(q);
    q.item = make_item(nps_pkg::ModeQuery, 0, CoordMin, CoordMin, 0, 0, 0, 1);
    items_to_send.push_back(q);

    for (i = 0; i < 3 * ItemsPerPhase; i++) begin
      q.phase = i / ItemsPerPhase;
      q.drain_first = (i != 0 && i % ItemsPerPhase == 0);
      q.item = random_item();
      items_to_send.push_back(q);
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (items_to_send.size() != 0 || in_valid) @(negedge clk);
    while (wanted_results.size() != 0) @(negedge clk);
    repeat (TailCycles) @(negedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
